>>> design/capsule_capsule_overlap_test_assert.svh
// assertion macros for the capsule overlap test checker
`ifndef CAPSULE_CAPSULE_OVERLAP_TEST_ASSERT_SVH
`define CAPSULE_CAPSULE_OVERLAP_TEST_ASSERT_SVH

// property checked on every clock edge outside reset
`define CCOT_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every clock edge, reset included
`define CCOT_ASSERT_ALL(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/ccot_pkg.sv
// shared constants for the capsule overlap test
package ccot_pkg;
  localparam int POINT_W = 48;
  localparam int RADIUS_W = 17;
  localparam int COORD_BITS_DEF = 16;
  localparam int FRACTION_BITS_DEF = 16;
endpackage

>>> design/ccot_mul.sv
// two-stage signed multiplier built from four half-width partial products
module ccot_mul #(
  parameter int WA = 16,
  parameter int WB = 16
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [WA-1:0]    a,
  input  logic signed [WB-1:0]    b,
  output logic signed [WA+WB-1:0] p
);
  localparam int PW = WA + WB;
  localparam int HA = (WA + 1) / 2;
  localparam int HB = (WB + 1) / 2;

  logic [WA-1:0] ma;
  logic [WB-1:0] mb;
  logic [HA+HB-1:0] ll_r;
  logic [HA+WB-HB-1:0] lh_r;
  logic [WA-HA+HB-1:0] hl_r;
  logic [WA-HA+WB-HB-1:0] hh_r;
  logic neg_r;
  logic [PW-1:0] sum;
  logic signed [PW-1:0] prod_r;

  assign ma = a[WA-1] ? (~$unsigned(a) + WA'(1)) : $unsigned(a);
  assign mb = b[WB-1] ? (~$unsigned(b) + WB'(1)) : $unsigned(b);

  always_ff @(posedge clk) begin
    if (en) begin
      ll_r  <= (HA+HB)'(ma[HA-1:0]) * (HA+HB)'(mb[HB-1:0]);
      lh_r  <= (HA+WB-HB)'(ma[HA-1:0]) * (HA+WB-HB)'(mb[WB-1:HB]);
      hl_r  <= (WA-HA+HB)'(ma[WA-1:HA]) * (WA-HA+HB)'(mb[HB-1:0]);
      hh_r  <= (WA-HA+WB-HB)'(ma[WA-1:HA]) * (WA-HA+WB-HB)'(mb[WB-1:HB]);
      neg_r <= a[WA-1] ^ b[WB-1];
    end
  end

  assign sum = PW'(ll_r) + (PW'(lh_r) << HB) + (PW'(hl_r) << HA) + (PW'(hh_r) << (HA + HB));

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= neg_r ? $signed(~sum + PW'(1)) : $signed(sum);
    end
  end

  assign p = prod_r;
endmodule

>>> design/ccot_div.sv
// pipelined clamped fraction divider, one quotient bit per stage
module ccot_div #(
  parameter int W  = 32,
  parameter int F  = 16,
  parameter int PW = 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_v,
  input  logic signed [W-1:0] num,
  input  logic signed [W-1:0] den,
  input  logic [PW-1:0]       in_pay,
  output logic                out_v,
  output logic [F:0]          q,
  output logic [PW-1:0]       out_pay
);
  localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

  logic          v_r    [F+1];
  logic          done_r [F+1];
  logic [F:0]    q_r    [F+1];
  logic [PW-1:0] pay_r  [F+1];
  logic [W-1:0]  rem_r  [F];
  logic [W-1:0]  den_r  [F];
  logic          num_pos;

  assign num_pos = !num[W-1] && (|num);

  // entry stage: settle the clamped cases up front
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pay_r[0] <= in_pay;
      rem_r[0] <= $unsigned(num);
      den_r[0] <= $unsigned(den);
      if (!num_pos) begin
        done_r[0] <= 1'b1;
        q_r[0]    <= '0;
      end else if (num >= den) begin
        done_r[0] <= 1'b1;
        q_r[0]    <= ONE;
      end else begin
        done_r[0] <= 1'b0;
        q_r[0]    <= '0;
      end
    end
  end

  for (genvar i = 1; i <= F; i++) begin : g_step
    logic [W-1:0] rem2;
    logic [W:0]   diff;
    logic         qbit;

    assign rem2 = {rem_r[i-1][W-2:0], 1'b0};
    assign diff = {1'b0, rem2} - {1'b0, den_r[i-1]};
    assign qbit = !diff[W];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= v_r[i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        pay_r[i]  <= pay_r[i-1];
        done_r[i] <= done_r[i-1];
        q_r[i]    <= done_r[i-1] ? q_r[i-1] : {q_r[i-1][F-1:0], qbit};
      end
    end

    if (i < F) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[i] <= qbit ? diff[W-1:0] : rem2;
          den_r[i] <= den_r[i-1];
        end
      end
    end
  end

  assign out_v   = v_r[F];
  assign q       = q_r[F];
  assign out_pay = pay_r[F];
endmodule

>>> design/ccot_dot.sv
// front end: lane unpack, axis and offset vectors, the five dot products
module ccot_dot #(
  parameter int C = ccot_pkg::COORD_BITS_DEF,
  localparam int DW = C + 1,
  localparam int DOTW = 2 * C + 3
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_v,
  input  logic [ccot_pkg::POINT_W-1:0]  p1,
  input  logic [ccot_pkg::POINT_W-1:0]  q1,
  input  logic [ccot_pkg::POINT_W-1:0]  p2,
  input  logic [ccot_pkg::POINT_W-1:0]  q2,
  input  logic [ccot_pkg::RADIUS_W-1:0] radius_in,
  output logic                          out_v,
  output logic signed [DOTW-1:0]        a,
  output logic signed [DOTW-1:0]        b,
  output logic signed [DOTW-1:0]        c,
  output logic signed [DOTW-1:0]        e,
  output logic signed [DOTW-1:0]        f,
  output logic [2:0][DW-1:0]            d1,
  output logic [2:0][DW-1:0]            d2,
  output logic [2:0][DW-1:0]            r,
  output logic [ccot_pkg::RADIUS_W-1:0] radius_out
);
  localparam int XW  = (3 * C > ccot_pkg::POINT_W) ? 3 * C : ccot_pkg::POINT_W;
  localparam int PRW = 2 * DW;

  logic [XW-1:0] xp1, xq1, xp2, xq2;
  logic v1_r, v2_r, v3_r;
  logic [2:0][DW-1:0] d1_s1_r, d2_s1_r, r_s1_r;
  logic [2:0][DW-1:0] d1_s2_r, d2_s2_r, r_s2_r;
  logic [2:0][DW-1:0] d1_s3_r, d2_s3_r, r_s3_r;
  logic [ccot_pkg::RADIUS_W-1:0] rad_s1_r, rad_s2_r, rad_s3_r;
  logic signed [PRW-1:0] aa_r [3];
  logic signed [PRW-1:0] ee_r [3];
  logic signed [PRW-1:0] ff_r [3];
  logic signed [PRW-1:0] cc_r [3];
  logic signed [PRW-1:0] bb_r [3];
  logic signed [DOTW-1:0] a_r, b_r, c_r, e_r, f_r;

  assign xp1 = XW'(p1);
  assign xq1 = XW'(q1);
  assign xp2 = XW'(p2);
  assign xq2 = XW'(q2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_v;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        d1_s1_r[k] <= DW'($signed(xq1[k*C +: C])) - DW'($signed(xp1[k*C +: C]));
        d2_s1_r[k] <= DW'($signed(xq2[k*C +: C])) - DW'($signed(xp2[k*C +: C]));
        r_s1_r[k]  <= DW'($signed(xp1[k*C +: C])) - DW'($signed(xp2[k*C +: C]));
      end
      rad_s1_r <= radius_in;

      for (int k = 0; k < 3; k++) begin
        aa_r[k] <= $signed(d1_s1_r[k]) * $signed(d1_s1_r[k]);
        ee_r[k] <= $signed(d2_s1_r[k]) * $signed(d2_s1_r[k]);
        ff_r[k] <= $signed(d2_s1_r[k]) * $signed(r_s1_r[k]);
        cc_r[k] <= $signed(d1_s1_r[k]) * $signed(r_s1_r[k]);
        bb_r[k] <= $signed(d1_s1_r[k]) * $signed(d2_s1_r[k]);
      end
      d1_s2_r  <= d1_s1_r;
      d2_s2_r  <= d2_s1_r;
      r_s2_r   <= r_s1_r;
      rad_s2_r <= rad_s1_r;

      a_r <= DOTW'(aa_r[0]) + DOTW'(aa_r[1]) + DOTW'(aa_r[2]);
      e_r <= DOTW'(ee_r[0]) + DOTW'(ee_r[1]) + DOTW'(ee_r[2]);
      f_r <= DOTW'(ff_r[0]) + DOTW'(ff_r[1]) + DOTW'(ff_r[2]);
      c_r <= DOTW'(cc_r[0]) + DOTW'(cc_r[1]) + DOTW'(cc_r[2]);
      b_r <= DOTW'(bb_r[0]) + DOTW'(bb_r[1]) + DOTW'(bb_r[2]);
      d1_s3_r  <= d1_s2_r;
      d2_s3_r  <= d2_s2_r;
      r_s3_r   <= r_s2_r;
      rad_s3_r <= rad_s2_r;
    end
  end

  assign out_v      = v3_r;
  assign a          = a_r;
  assign b          = b_r;
  assign c          = c_r;
  assign e          = e_r;
  assign f          = f_r;
  assign d1         = d1_s3_r;
  assign d2         = d2_s3_r;
  assign r          = r_s3_r;
  assign radius_out = rad_s3_r;
endmodule

>>> design/capsule_capsule_overlap_test.sv
// top level of the pipelined capsule against capsule overlap test
//
// usage
//   input channel: in_valid / in_ready, one item per pair of capsules: the
//   two axis end points of each capsule (x, y, z packed as COORD_BITS-bit
//   signed lanes, x lowest) and the sum of both radii
//   output channel: out_valid / out_ready, one item per input item, in order;
//   out_overlap is 1 when the closest axis points lie within radius_sum
//   throughput: one item per cycle while in_ready is high, no state is kept between items
//   most of the pipeline depth lies in the two 1-bit-per-stage parameter
//   dividers, one for s, one for t or the re-clamped s
//   reset (rst_n low, synchronous): all valid bits clear, nothing in flight
//   receiver stall: a two-entry output buffer lets one more item in after
//   out_ready drops, then in_ready goes low and the whole pipe holds; in_ready
//   returns the cycle after out_ready comes back
module capsule_capsule_overlap_test #(
  parameter int COORD_BITS    = ccot_pkg::COORD_BITS_DEF,
  parameter int FRACTION_BITS = ccot_pkg::FRACTION_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ccot_pkg::POINT_W-1:0]  in_first_top,
  input  logic [ccot_pkg::POINT_W-1:0]  in_first_bottom,
  input  logic [ccot_pkg::POINT_W-1:0]  in_second_top,
  input  logic [ccot_pkg::POINT_W-1:0]  in_second_bottom,
  input  logic [ccot_pkg::RADIUS_W-1:0] in_radius_sum,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_overlap
);
  localparam int C    = COORD_BITS;
  localparam int F    = FRACTION_BITS;
  localparam int RW   = ccot_pkg::RADIUS_W;
  localparam int DW   = C + 1;
  localparam int DOTW = 2 * C + 3;
  localparam int NW   = 2 * DOTW + 1;      // s numerator / denominator
  localparam int W2   = DOTW + F + 3;      // t numerator / denominator
  localparam int DKW  = DW + F + 3;        // closest point difference
  localparam int SQW  = 2 * DKW + 2;       // squared distance
  localparam int CMPW = SQW + 2 * RW + 2 * F;
  localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

  typedef logic [2:0][DW-1:0] vec3_t;

  typedef struct packed {
    vec3_t         d1;
    vec3_t         d2;
    vec3_t         r;
    logic [RW-1:0] radius;
  } dist_t;

  typedef struct packed {
    logic signed [DOTW-1:0] a;
    logic signed [DOTW-1:0] b;
    logic signed [DOTW-1:0] c;
    logic signed [DOTW-1:0] e;
    logic signed [DOTW-1:0] f;
    dist_t                  dv;
  } geo_t;

  typedef enum logic [1:0] {
    CASE_BOTH = 2'd0,   // both axes collapse to a point
    CASE_AZ   = 2'd1,   // first axis is a point
    CASE_EZ   = 2'd2,   // second axis is a point
    CASE_GEN  = 2'd3
  } case_t;

  typedef enum logic [1:0] {
    DEST_NONE = 2'd0,
    DEST_S    = 2'd1,
    DEST_T    = 2'd2
  } dest_t;

  typedef struct packed {
    case_t cs;
    geo_t  g;
  } d1pay_t;

  typedef struct packed {
    dest_t      dest;
    logic [F:0] s_keep;
    logic [F:0] t_keep;
    dist_t      dv;
  } d2pay_t;

  // global advance: the pipe moves unless the output buffer is full
  logic en;
  logic skid_v_r, skid_hit_r, out_v_r, out_hit_r;

  assign en       = !skid_v_r;
  assign in_ready = en;

  // ---------------------------------------------------------------- dot products
  logic dot_v;
  logic signed [DOTW-1:0] dot_a, dot_b, dot_c, dot_e, dot_f;
  vec3_t dot_d1, dot_d2, dot_r;
  logic [RW-1:0] dot_rad;
  geo_t g3;

  ccot_dot #(.C(C)) u_dot (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_v       (in_valid),
    .p1         (in_first_top),
    .q1         (in_first_bottom),
    .p2         (in_second_top),
    .q2         (in_second_bottom),
    .radius_in  (in_radius_sum),
    .out_v      (dot_v),
    .a          (dot_a),
    .b          (dot_b),
    .c          (dot_c),
    .e          (dot_e),
    .f          (dot_f),
    .d1         (dot_d1),
    .d2         (dot_d2),
    .r          (dot_r),
    .radius_out (dot_rad)
  );

  always_comb begin
    g3.a         = dot_a;
    g3.b         = dot_b;
    g3.c         = dot_c;
    g3.e         = dot_e;
    g3.f         = dot_f;
    g3.dv.d1     = dot_d1;
    g3.dv.d2     = dot_d2;
    g3.dv.r      = dot_r;
    g3.dv.radius = dot_rad;
  end

  // ---------------------------------------------------------------- a*e, b*b, b*f, c*e
  logic signed [2*DOTW-1:0] ae, bb, bf, ce;
  logic m1_v_r, m2_v_r;
  geo_t m1_g_r, m2_g_r;

  ccot_mul #(.WA(DOTW), .WB(DOTW)) u_mul_ae (.clk(clk), .en(en), .a(g3.a), .b(g3.e), .p(ae));
  ccot_mul #(.WA(DOTW), .WB(DOTW)) u_mul_bb (.clk(clk), .en(en), .a(g3.b), .b(g3.b), .p(bb));
  ccot_mul #(.WA(DOTW), .WB(DOTW)) u_mul_bf (.clk(clk), .en(en), .a(g3.b), .b(g3.f), .p(bf));
  ccot_mul #(.WA(DOTW), .WB(DOTW)) u_mul_ce (.clk(clk), .en(en), .a(g3.c), .b(g3.e), .p(ce));

  // ---------------------------------------------------------------- pick the first division
  logic signed [NW-1:0] denom, snum, p_num_nxt, p_den_nxt;
  case_t p_case_nxt;
  logic p_v_r;
  logic signed [NW-1:0] p_num_r, p_den_r;
  d1pay_t p_pay_r;

  always_comb begin
    denom = NW'(ae) - NW'(bb);
    snum  = NW'(bf) - NW'(ce);
    if (m2_g_r.a == '0 && m2_g_r.e == '0) begin
      p_case_nxt = CASE_BOTH;
    end else if (m2_g_r.a == '0) begin
      p_case_nxt = CASE_AZ;
    end else if (m2_g_r.e == '0) begin
      p_case_nxt = CASE_EZ;
    end else begin
      p_case_nxt = CASE_GEN;
    end
    // a zero numerator over one yields a zero quotient
    p_num_nxt = '0;
    p_den_nxt = NW'(1);
    unique case (p_case_nxt)
      CASE_AZ: begin
        p_num_nxt = NW'(m2_g_r.f);
        p_den_nxt = NW'(m2_g_r.e);
      end
      CASE_EZ: begin
        p_num_nxt = -NW'(m2_g_r.c);
        p_den_nxt = NW'(m2_g_r.a);
      end
      CASE_GEN: begin
        // parallel axes: s stays 0
        if (!denom[NW-1] && (|denom)) begin
          p_num_nxt = snum;
          p_den_nxt = denom;
        end
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------- first divider
  logic d1_v;
  logic [F:0] q1;
  logic [$bits(d1pay_t)-1:0] d1_out;
  d1pay_t d1_res;

  ccot_div #(.W(NW), .F(F), .PW($bits(d1pay_t))) u_div_s (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_v    (p_v_r),
    .num     (p_num_r),
    .den     (p_den_r),
    .in_pay  (p_pay_r),
    .out_v   (d1_v),
    .q       (q1),
    .out_pay (d1_out)
  );

  assign d1_res = d1pay_t'(d1_out);

  // ---------------------------------------------------------------- t numerator b*s + f
  logic signed [DOTW+F+1:0] bs;
  logic t1_v_r, t2_v_r;
  d1pay_t t1_pay_r, t2_pay_r;
  logic [F:0] t1_q_r, t2_q_r;

  ccot_mul #(.WA(DOTW), .WB(F + 2)) u_mul_bs (
    .clk (clk),
    .en  (en),
    .a   (d1_res.g.b),
    .b   ($signed({1'b0, q1})),
    .p   (bs)
  );

  logic u1_v_r;
  logic signed [W2-1:0] u1_tnum_r, u1_tden_r;
  d1pay_t u1_pay_r;
  logic [F:0] u1_q_r;

  // ---------------------------------------------------------------- t clamp, second division
  logic signed [W2-1:0] u2_num_nxt, u2_den_nxt;
  d2pay_t u2_pay_nxt;
  logic u2_v_r;
  logic signed [W2-1:0] u2_num_r, u2_den_r;
  d2pay_t u2_pay_r;

  always_comb begin
    u2_num_nxt        = '0;
    u2_den_nxt        = W2'(1);
    u2_pay_nxt.dest   = DEST_NONE;
    u2_pay_nxt.s_keep = '0;
    u2_pay_nxt.t_keep = '0;
    u2_pay_nxt.dv     = u1_pay_r.g.dv;
    unique case (u1_pay_r.cs)
      CASE_AZ: begin
        u2_pay_nxt.t_keep = u1_q_r;
      end
      CASE_EZ: begin
        u2_pay_nxt.s_keep = u1_q_r;
      end
      CASE_GEN: begin
        if (u1_tnum_r[W2-1]) begin
          // t below 0: t = 0, s re-clamped from -c / a
          u2_num_nxt      = -W2'(u1_pay_r.g.c);
          u2_den_nxt      = W2'(u1_pay_r.g.a);
          u2_pay_nxt.dest = DEST_S;
        end else if (u1_tnum_r > u1_tden_r) begin
          // t above 1: t = 1, s re-clamped from (b - c) / a
          u2_num_nxt        = W2'(u1_pay_r.g.b) - W2'(u1_pay_r.g.c);
          u2_den_nxt        = W2'(u1_pay_r.g.a);
          u2_pay_nxt.dest   = DEST_S;
          u2_pay_nxt.t_keep = ONE;
        end else begin
          u2_num_nxt        = u1_tnum_r;
          u2_den_nxt        = u1_tden_r;
          u2_pay_nxt.dest   = DEST_T;
          u2_pay_nxt.s_keep = u1_q_r;
        end
      end
      default: begin
      end
    endcase
  end

  logic d2_v;
  logic [F:0] q2;
  logic [$bits(d2pay_t)-1:0] d2_out;
  d2pay_t d2_res;

  ccot_div #(.W(W2), .F(F), .PW($bits(d2pay_t))) u_div_t (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_v    (u2_v_r),
    .num     (u2_num_r),
    .den     (u2_den_r),
    .in_pay  (u2_pay_r),
    .out_v   (d2_v),
    .q       (q2),
    .out_pay (d2_out)
  );

  assign d2_res = d2pay_t'(d2_out);

  // ---------------------------------------------------------------- closest point difference
  logic [F:0] s_fin, t_fin;
  logic v_v_r, w_v_r;
  logic signed [DW+F+1:0] v_d1s_r [3];
  logic signed [DW+F+1:0] v_d2t_r [3];
  vec3_t v_r_r;
  logic [RW-1:0] v_rad_r;
  logic signed [DKW-1:0] w_dk_r [3];
  logic [2*RW-1:0] w_lim_r;

  always_comb begin
    s_fin = (d2_res.dest == DEST_S) ? q2 : d2_res.s_keep;
    t_fin = (d2_res.dest == DEST_T) ? q2 : d2_res.t_keep;
  end

  // ---------------------------------------------------------------- squared distance and compare
  logic signed [2*DKW-1:0] sq [3];
  logic x1_v_r, x2_v_r;
  logic [2*RW-1:0] x1_lim_r, x2_lim_r;
  logic y_v_r, z_v_r, z_hit_r;
  logic signed [SQW-1:0] y_sum_r;
  logic [2*RW-1:0] y_lim_r;

  for (genvar k = 0; k < 3; k++) begin : g_sq
    ccot_mul #(.WA(DKW), .WB(DKW)) u_mul_sq (
      .clk (clk),
      .en  (en),
      .a   (w_dk_r[k]),
      .b   (w_dk_r[k]),
      .p   (sq[k])
    );
  end

  // ---------------------------------------------------------------- valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_v_r <= 1'b0;
      m2_v_r <= 1'b0;
      p_v_r  <= 1'b0;
      t1_v_r <= 1'b0;
      t2_v_r <= 1'b0;
      u1_v_r <= 1'b0;
      u2_v_r <= 1'b0;
      v_v_r  <= 1'b0;
      w_v_r  <= 1'b0;
      x1_v_r <= 1'b0;
      x2_v_r <= 1'b0;
      y_v_r  <= 1'b0;
      z_v_r  <= 1'b0;
    end else if (en) begin
      m1_v_r <= dot_v;
      m2_v_r <= m1_v_r;
      p_v_r  <= m2_v_r;
      t1_v_r <= d1_v;
      t2_v_r <= t1_v_r;
      u1_v_r <= t2_v_r;
      u2_v_r <= u1_v_r;
      v_v_r  <= d2_v;
      w_v_r  <= v_v_r;
      x1_v_r <= w_v_r;
      x2_v_r <= x1_v_r;
      y_v_r  <= x2_v_r;
      z_v_r  <= y_v_r;
    end
  end

  // ---------------------------------------------------------------- datapath registers
  always_ff @(posedge clk) begin
    if (en) begin
      m1_g_r <= g3;
      m2_g_r <= m1_g_r;

      p_num_r    <= p_num_nxt;
      p_den_r    <= p_den_nxt;
      p_pay_r.cs <= p_case_nxt;
      p_pay_r.g  <= m2_g_r;

      t1_pay_r <= d1_res;
      t1_q_r   <= q1;
      t2_pay_r <= t1_pay_r;
      t2_q_r   <= t1_q_r;

      u1_tnum_r <= W2'(bs) + (W2'(t2_pay_r.g.f) <<< F);
      u1_tden_r <= W2'(t2_pay_r.g.e) <<< F;
      u1_pay_r  <= t2_pay_r;
      u1_q_r    <= t2_q_r;

      u2_num_r <= u2_num_nxt;
      u2_den_r <= u2_den_nxt;
      u2_pay_r <= u2_pay_nxt;

      for (int k = 0; k < 3; k++) begin
        v_d1s_r[k] <= $signed(d2_res.dv.d1[k]) * $signed({1'b0, s_fin});
        v_d2t_r[k] <= $signed(d2_res.dv.d2[k]) * $signed({1'b0, t_fin});
      end
      v_r_r   <= d2_res.dv.r;
      v_rad_r <= d2_res.dv.radius;

      // r * one + d1 * s - d2 * t, exact in units of 2^-F
      for (int k = 0; k < 3; k++) begin
        w_dk_r[k] <= (DKW'($signed(v_r_r[k])) <<< F) + DKW'(v_d1s_r[k]) - DKW'(v_d2t_r[k]);
      end
      w_lim_r <= v_rad_r * v_rad_r;

      x1_lim_r <= w_lim_r;
      x2_lim_r <= x1_lim_r;

      y_sum_r <= SQW'(sq[0]) + SQW'(sq[1]) + SQW'(sq[2]);
      y_lim_r <= x2_lim_r;

      // radius scaled by one, squared: radius^2 shifted by 2F
      z_hit_r <= CMPW'($unsigned(y_sum_r)) <= (CMPW'(y_lim_r) << (2 * F));
    end
  end

  // ---------------------------------------------------------------- output register and skid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || out_ready) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= z_v_r;
      end
    end else if (z_v_r) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || out_ready) begin
      out_hit_r <= skid_v_r ? skid_hit_r : z_hit_r;
    end else if (z_v_r && !skid_v_r) begin
      skid_hit_r <= z_hit_r;
    end
  end

  assign out_valid   = out_v_r;
  assign out_overlap = out_hit_r;
endmodule

>>> design/ccot_checker.sv
// port-level checker for the capsule overlap test, bound to the top level
`include "capsule_capsule_overlap_test_assert.svh"

module ccot_checker (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_overlap
);
  `CCOT_ASSERT_ALL(a_rst_empties_out, !rst_n |=> !out_valid, "output valid after reset")
  `CCOT_ASSERT(a_out_holds, out_valid && !out_ready |=> out_valid && $stable(out_overlap), "stalled result changed")
  `CCOT_ASSERT(a_stall_has_cause, !in_ready |-> $past(out_valid && !out_ready), "input blocked without output stall")
  `CCOT_ASSERT(a_stall_releases, !in_ready && out_ready |=> in_ready, "input stays blocked after output drains")
endmodule

bind capsule_capsule_overlap_test ccot_checker u_ccot_checker (.*);

>>> tb/sv/tb_capsule_capsule_overlap_test.sv
// testbench for the capsule against capsule overlap test
module tb_capsule_capsule_overlap_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int POINT_W = ccot_pkg::POINT_W;
  localparam int RADIUS_W = ccot_pkg::RADIUS_W;
  localparam int CB = ccot_pkg::COORD_BITS_DEF;
  localparam int FB = ccot_pkg::FRACTION_BITS_DEF;
  localparam int LATENCY = 2 * FB + 19;
  localparam int IDLE_LIMIT = 20000;
  localparam int N_RANDOM = 400;
  localparam int HOLD_OFF = 300;

  typedef struct packed {
    logic [POINT_W-1:0]  first_top;
    logic [POINT_W-1:0]  first_bottom;
    logic [POINT_W-1:0]  second_top;
    logic [POINT_W-1:0]  second_bottom;
    logic [RADIUS_W-1:0] radius_sum;
  } pair_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [POINT_W-1:0] in_first_top = '0;
  logic [POINT_W-1:0] in_first_bottom = '0;
  logic [POINT_W-1:0] in_second_top = '0;
  logic [POINT_W-1:0] in_second_bottom = '0;
  logic [RADIUS_W-1:0] in_radius_sum = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_overlap;

  pair_t pending_pairs[$];
  logic  expected_hits[$];
  int    errors = 0;
  bit    stim_done = 1'b0;
  int    idle_cycles = 0;
  int    send_gap = 0;
  int    recv_gap = 0;
  int    hold_count = 0;
  int    hold_trigger;

  capsule_capsule_overlap_test i_dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // random gap length: mostly zero or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [CB-1:0] coord(logic [POINT_W-1:0] p, int k);
    return p[k*CB +: CB];
  endfunction

  // clamp(floor(num/den * 2^FB), 0, 2^FB), den > 0
  function automatic longint unsigned frac_quot(logic signed [127:0] num,
                                                logic signed [127:0] den);
    logic signed [127:0] q;
    if (num <= 0) return 0;
    if (num >= den) return 64'd1 << FB;
    q = (num <<< FB) / den;
    return 64'(q);
  endfunction

  // closest points of the two axes, squared distance against squared radius
  function automatic logic predict_overlap(pair_t p);
    logic signed [63:0] d1[3], d2[3], r[3];
    logic signed [63:0] a, e, f, c, b;
    logic signed [127:0] s, t, denom, tnum, tden, dk, dist2, lim, one;
    one = 128'sd1 <<< FB;
    for (int k = 0; k < 3; k++) begin
      d1[k] = coord(p.first_bottom, k) - coord(p.first_top, k);
      d2[k] = coord(p.second_bottom, k) - coord(p.second_top, k);
      r[k]  = coord(p.first_top, k) - coord(p.second_top, k);
    end
    a = d1[0]*d1[0] + d1[1]*d1[1] + d1[2]*d1[2];
    e = d2[0]*d2[0] + d2[1]*d2[1] + d2[2]*d2[2];
    f = d2[0]*r[0] + d2[1]*r[1] + d2[2]*r[2];
    c = d1[0]*r[0] + d1[1]*r[1] + d1[2]*r[2];
    b = d1[0]*d2[0] + d1[1]*d2[1] + d1[2]*d2[2];
    if (a == 0 && e == 0) begin
      s = 0;
      t = 0;
    end else if (a == 0) begin
      s = 0;
      t = frac_quot(f, e);
    end else if (e == 0) begin
      t = 0;
      s = frac_quot(-c, a);
    end else begin
      denom = 128'(a) * 128'(e) - 128'(b) * 128'(b);
      // parallel axes skip the division
      if (denom > 0) s = frac_quot(128'(b) * 128'(f) - 128'(c) * 128'(e), denom);
      else s = 0;
      tnum = 128'(b) * s + 128'(f) * one;
      tden = 128'(e) * one;
      if (tnum < 0) begin
        t = 0;
        s = frac_quot(-c, a);
      end else if (tnum > tden) begin
        t = one;
        s = frac_quot(b - c, a);
      end else begin
        t = frac_quot(tnum, tden);
      end
    end
    dist2 = 0;
    for (int k = 0; k < 3; k++) begin
      dk = 128'(r[k]) * one + 128'(d1[k]) * s - 128'(d2[k]) * t;
      dist2 += dk * dk;
    end
    lim = 128'(p.radius_sum) * one;
    lim = lim * lim;
    return dist2 <= lim;
  endfunction

  function automatic logic [POINT_W-1:0] pack_point(int x, int y, int z);
    return {CB'(z), CB'(y), CB'(x)};
  endfunction

  function automatic logic [POINT_W-1:0] rand_point(int span);
    return pack_point($urandom_range(0, 2*span) - span, $urandom_range(0, 2*span) - span,
                      $urandom_range(0, 2*span) - span);
  endfunction

  function automatic pair_t make_pair(logic [POINT_W-1:0] a0, logic [POINT_W-1:0] a1,
                                      logic [POINT_W-1:0] b0, logic [POINT_W-1:0] b1,
                                      int rs);
    pair_t p;
    p.first_top = a0;
    p.first_bottom = a1;
    p.second_top = b0;
    p.second_bottom = b1;
    p.radius_sum = RADIUS_W'(rs);
    return p;
  endfunction

  // driver: holds valid and payload until accepted
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        void'(pending_pairs.pop_front());
        send_gap = pick_gap();
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_pairs.size() > 0) begin
          in_valid <= 1'b1;
          in_first_top <= pending_pairs[0].first_top;
          in_first_bottom <= pending_pairs[0].first_bottom;
          in_second_top <= pending_pairs[0].second_top;
          in_second_bottom <= pending_pairs[0].second_bottom;
          in_radius_sum <= pending_pairs[0].radius_sum;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // prediction at accept time
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      expected_hits.push_back(predict_overlap({in_first_top, in_first_bottom, in_second_top,
                                               in_second_bottom, in_radius_sum}));
  end

  // receiver: random stalls plus one long hold-off while the sender keeps going
  always @(posedge clk) begin
    if (rst_n) begin
      if (hold_trigger > 0) begin
        hold_trigger--;
        if (hold_trigger == 0) hold_count = HOLD_OFF;
      end
      if (hold_count > 0) begin
        hold_count--;
        out_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        recv_gap = pick_gap();
      end
    end
  end

  // monitor: compare each result against the oldest expectation
  always @(posedge clk) begin
    logic exp_hit;
    if (rst_n && out_valid && out_ready) begin
      if (expected_hits.size() == 0) begin
        $display("%0t: unexpected result overlap=%0b", $realtime, out_overlap);
        errors++;
      end else begin
        exp_hit = expected_hits.pop_front();
        if (out_overlap !== exp_hit) begin
          $display("%0t: overlap mismatch expected %0b actual %0b",
                   $realtime, exp_hit, out_overlap);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_capsule_capsule_overlap_test NOT OK");
      $finish;
    end
  end

  initial begin
    int span;
    logic [POINT_W-1:0] p0, p1;
    hold_trigger = 100;
    // directed: degenerate, parallel, crossing, extremes, touching
    pending_pairs.push_back(make_pair('0, '0, '0, '0, 0));
    pending_pairs.push_back(make_pair('1, '1, '1, '1, 0));
    pending_pairs.push_back(make_pair(pack_point(0,0,0), pack_point(0,0,0),
                                      pack_point(3,0,0), pack_point(3,0,0), 3));
    pending_pairs.push_back(make_pair(pack_point(0,0,0), pack_point(0,0,0),
                                      pack_point(3,0,0), pack_point(3,0,0), 2));
    pending_pairs.push_back(make_pair(pack_point(0,0,0), pack_point(0,0,0),
                                      pack_point(-5,4,0), pack_point(5,4,0), 4));
    pending_pairs.push_back(make_pair(pack_point(-5,4,0), pack_point(5,4,0),
                                      pack_point(0,0,0), pack_point(0,0,0), 3));
    pending_pairs.push_back(make_pair(pack_point(0,0,0), pack_point(10,0,0),
                                      pack_point(0,2,0), pack_point(10,2,0), 2));
    pending_pairs.push_back(make_pair(pack_point(0,0,0), pack_point(10,0,0),
                                      pack_point(20,1,0), pack_point(30,1,0), 10));
    pending_pairs.push_back(make_pair(pack_point(0,0,0), pack_point(10,0,0),
                                      pack_point(30,1,0), pack_point(20,1,0), 9));
    pending_pairs.push_back(make_pair(pack_point(-10,0,0), pack_point(10,0,0),
                                      pack_point(0,-10,5), pack_point(0,10,5), 5));
    pending_pairs.push_back(make_pair(pack_point(-10,0,0), pack_point(10,0,0),
                                      pack_point(0,-10,5), pack_point(0,10,5), 4));
    pending_pairs.push_back(make_pair(pack_point(0,0,0), pack_point(10,0,0),
                                      pack_point(-5,-10,1), pack_point(-5,10,1), 5));
    pending_pairs.push_back(make_pair(pack_point(0,0,0), pack_point(10,0,0),
                                      pack_point(15,3,-20), pack_point(15,3,20), 6));
    pending_pairs.push_back(make_pair(pack_point(-32768,-32768,-32768),
                                      pack_point(32767,32767,32767),
                                      pack_point(32767,-32768,32767),
                                      pack_point(-32768,32767,-32768), 131070));
    pending_pairs.push_back(make_pair(pack_point(-32768,-32768,-32768),
                                      pack_point(-32768,-32768,-32768),
                                      pack_point(32767,32767,32767),
                                      pack_point(32767,32767,32767), 131070));
    pending_pairs.push_back(make_pair(pack_point(-32768,-32768,-32768),
                                      pack_point(-32768,-32768,-32768),
                                      pack_point(32767,32767,32767),
                                      pack_point(32767,32767,32767), 1));
    pending_pairs.push_back(make_pair(pack_point(1,2,3),
                                      48'hffff_0000_8000, 48'h7fff_8000_0001,
                                      48'h0000_7fff_ffff, 17'h1ffff));
    // random: mix of small and full-range coordinates, radius drawn at random
    for (int i = 0; i < N_RANDOM; i++) begin
      case ($urandom_range(0, 5))
        0: span = 32767;
        1: span = 1000;
        2: span = 2;
        default: span = 60;
      endcase
      p0 = rand_point(span);
      p1 = ($urandom_range(0, 9) == 0) ? p0 : rand_point(span);
      if (span == 32767)
        pending_pairs.push_back(make_pair(POINT_W'({$urandom, $urandom}),
                                          POINT_W'({$urandom, $urandom}),
                                          POINT_W'({$urandom, $urandom}),
                                          POINT_W'({$urandom, $urandom}),
                                          $urandom_range(0, 131070)));
      else
        pending_pairs.push_back(make_pair(p0, p1, rand_point(span),
                                          ($urandom_range(0, 9) == 0) ? rand_point(0)
                                                                       : rand_point(span),
                                          $urandom_range(0, 2 * span)));
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_pairs.size() == 0);
    // let the last accepted item reach the expectation queue
    @(posedge clk);
    wait (expected_hits.size() == 0);
    repeat (LATENCY + 20) @(posedge clk);
    if (errors == 0 && expected_hits.size() == 0) $display("tb_capsule_capsule_overlap_test OK");
    else $display("tb_capsule_capsule_overlap_test NOT OK");
    $finish;
  end
endmodule
